[sv/mm_pkg.sv]
// Shared types and constants of the matrix multiply unit.
package mm_pkg;

   localparam int MAX_DIM_DEF   = 8;
   localparam int ELEM_BITS_DEF = 16;
   localparam int IDX_W         = 3;
   localparam int DIM_W         = 4;
   localparam int ACC_W         = 36;
   localparam int RSP_W         = 48;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic [IDX_W-1:0] k;
   } ctl_type;

endpackage

[sv/mm_cell.sv]
// One multiply-accumulate cell: holds one column of B and one element of C.
module mm_cell #(
   parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mm_pkg::ctl_type             ctl_in,
   input  logic signed [ELEM_BITS-1:0] a_in,
   input  logic                        b_we,
   input  logic [mm_pkg::IDX_W-1:0]    b_k,
   input  logic [ELEM_BITS-1:0]        b_data,
   output mm_pkg::ctl_type             ctl_out,
   output logic signed [ELEM_BITS-1:0] a_out,
   output logic [mm_pkg::ACC_W-1:0]    acc_out
);
   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [ELEM_BITS-1:0]          b_mem_ff [MAX_DIM];
   mm_pkg::ctl_type               ctl_ff;
   logic signed [ELEM_BITS-1:0]   a_ff;
   logic                          prod_vld_ff;
   logic                          prod_first_ff;
   logic signed [2*ELEM_BITS-1:0] prod_ff;
   logic signed [2*ELEM_BITS-1:0] prod_in;
   logic [mm_pkg::ACC_W-1:0]      prod_ext;
   logic [mm_pkg::ACC_W-1:0]      acc_ff;
   logic [mm_pkg::ACC_W-1:0]      acc_in;

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem_ff[b_k[IW-1:0]] <= b_data;
      end
   end

   assign prod_in  = a_in * $signed(b_mem_ff[ctl_in.k[IW-1:0]]);
   assign prod_ext = mm_pkg::ACC_W'(prod_ff);
   assign acc_in   = prod_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         ctl_ff      <= ctl_in;
         prod_vld_ff <= ctl_in.valid;
      end
      a_ff          <= a_in;
      prod_first_ff <= ctl_in.first;
      prod_ff       <= prod_in;
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign a_out   = a_ff;
   assign acc_out = acc_ff;
endmodule

[sv/matrix_multiply_unit.sv]
// Matrix multiply unit: load A and B, run a chain of MAC cells, stream out C.
// Flow: after the last B item, C is computed one row at a time: the A store read port feeds
// one item of A per cycle into the cell chain, then the row's cols_b results are sent out.
// Loading takes one item per cycle while no register write is offered.
// Reset: synchronous; dimensions return to 8, load restarts, stores keep stale data.
module matrix_multiply_unit #(
   parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((ELEM_BITS+7)/8)*8-1:0]        req_tdata,  // elem_value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mm_pkg::RSP_W-1:0]              rsp_tdata,  // result_value, result_row, result_col
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mm_pkg::DIM_W-1:0]              csr_data
);
   localparam int IW       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW       = 2 * IW;
   localparam int WAIT_CYC = MAX_DIM + 4;
   localparam int WW       = $clog2(WAIT_CYC + 1);
   localparam int DW       = mm_pkg::DIM_W;

   mm_pkg::state_type state_ff, state_in;

   logic [DW-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DW-1:0] ra, id, cb;

   logic [ELEM_BITS-1:0] a_mem [2**AW];
   logic signed [ELEM_BITS-1:0] a_rd_ff;

   logic [IW-1:0] ld_row_ff, ld_col_ff;
   logic          ld_b_ff;
   logic [IW-1:0] r_ff, k_ff, c_ff;
   logic [WW-1:0] wait_ff;
   mm_pkg::ctl_type iss_ff;

   logic req_go, csr_go, cfg_hit, out_go;
   logic ld_col_last, ld_row_last, k_last, r_last, c_last, wait_done;
   logic calc_en;

   mm_pkg::ctl_type             ctl_chain [MAX_DIM+1];
   logic signed [ELEM_BITS-1:0] a_chain   [MAX_DIM+1];
   logic [mm_pkg::ACC_W-1:0]    acc_arr   [MAX_DIM];
   logic [MAX_DIM-1:0]          b_we_vec;

   logic                     rsp_tvalid_ff;
   logic [mm_pkg::ACC_W-1:0] val_ff;
   logic [IW-1:0]            row_ff, col_ff;
   logic                     last_ff;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
      logic [DW-1:0] res;
      res = v;
      if (v == '0) begin
         res = DW'(1);
      end else if (int'(v) > MAX_DIM) begin
         res = DW'(MAX_DIM);
      end
      return res;
   endfunction

   assign ra = clamp_dim(rows_a_ff);
   assign id = clamp_dim(inner_dim_ff);
   assign cb = clamp_dim(cols_b_ff);

   assign req_go  = req_tvalid && req_tready;
   assign csr_go  = csr_valid && csr_ready;
   assign cfg_hit = csr_go && (csr_index == mm_pkg::CSR_ROWS_A ||
                               csr_index == mm_pkg::CSR_INNER_DIM ||
                               csr_index == mm_pkg::CSR_COLS_B);
   assign out_go  = (state_ff == mm_pkg::ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   assign ld_col_last = DW'(ld_col_ff) == (ld_b_ff ? cb : id) - DW'(1);
   assign ld_row_last = DW'(ld_row_ff) == (ld_b_ff ? id : ra) - DW'(1);
   assign k_last      = DW'(k_ff) == id - DW'(1);
   assign r_last      = DW'(r_ff) == ra - DW'(1);
   assign c_last      = DW'(c_ff) == cb - DW'(1);
   assign wait_done   = wait_ff == WW'(WAIT_CYC - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mm_pkg::ST_LOAD: begin
            if (req_go && ld_b_ff && ld_col_last && ld_row_last) begin
               state_in = mm_pkg::ST_CALC;
            end
         end
         mm_pkg::ST_CALC: begin
            if (k_last) begin
               state_in = mm_pkg::ST_WAIT;
            end
         end
         mm_pkg::ST_WAIT: begin
            if (wait_done) begin
               state_in = mm_pkg::ST_EMIT;
            end
         end
         mm_pkg::ST_EMIT: begin
            if (out_go && c_last) begin
               state_in = r_last ? mm_pkg::ST_LOAD : mm_pkg::ST_CALC;
            end
         end
         default: state_in = mm_pkg::ST_LOAD;
      endcase
   end

   // outputs; hold input items while a register write is offered
   always_comb begin
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      calc_en    = 1'b0;
      unique case (state_ff)
         mm_pkg::ST_LOAD: begin
            req_tready = !csr_valid;
            csr_ready  = 1'b1;
         end
         mm_pkg::ST_CALC: calc_en = 1'b1;
         mm_pkg::ST_WAIT, mm_pkg::ST_EMIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm_pkg::ST_LOAD;
         rows_a_ff    <= DW'(8);
         inner_dim_ff <= DW'(8);
         cols_b_ff    <= DW'(8);
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         ld_b_ff      <= 1'b0;
         r_ff         <= '0;
         k_ff         <= '0;
         c_ff         <= '0;
         wait_ff      <= '0;
         iss_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_go) begin
            unique case (csr_index)
               mm_pkg::CSR_ROWS_A:    rows_a_ff    <= csr_data;
               mm_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_data;
               mm_pkg::CSR_COLS_B:    cols_b_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cfg_hit) begin
            ld_row_ff <= '0;
            ld_col_ff <= '0;
            ld_b_ff   <= 1'b0;
         end else if (req_go) begin
            if (ld_col_last) begin
               ld_col_ff <= '0;
               if (ld_row_last) begin
                  ld_row_ff <= '0;
                  ld_b_ff   <= !ld_b_ff;
               end else begin
                  ld_row_ff <= ld_row_ff + IW'(1);
               end
            end else begin
               ld_col_ff <= ld_col_ff + IW'(1);
            end
         end
         iss_ff.valid <= calc_en;
         iss_ff.first <= k_ff == '0;
         iss_ff.k     <= mm_pkg::IDX_W'(k_ff);
         if (calc_en) begin
            k_ff <= k_last ? '0 : k_ff + IW'(1);
         end
         wait_ff <= (state_ff == mm_pkg::ST_WAIT) ? wait_ff + WW'(1) : '0;
         if (out_go) begin
            if (c_last) begin
               c_ff <= '0;
               r_ff <= r_last ? '0 : r_ff + IW'(1);
            end else begin
               c_ff <= c_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go && !ld_b_ff) begin
         a_mem[{ld_row_ff, ld_col_ff}] <= req_tdata[ELEM_BITS-1:0];
      end
      a_rd_ff <= $signed(a_mem[{r_ff, k_ff}]);
   end

   assign ctl_chain[0] = iss_ff;
   assign a_chain[0]   = a_rd_ff;

   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      assign b_we_vec[g] = req_go && ld_b_ff && (int'(ld_col_ff) == g);
      mm_cell #(
         .MAX_DIM   (MAX_DIM),
         .ELEM_BITS (ELEM_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_chain[g]),
         .a_in    (a_chain[g]),
         .b_we    (b_we_vec[g]),
         .b_k     (mm_pkg::IDX_W'(ld_row_ff)),
         .b_data  (req_tdata[ELEM_BITS-1:0]),
         .ctl_out (ctl_chain[g+1]),
         .a_out   (a_chain[g+1]),
         .acc_out (acc_arr[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (out_go) begin
         val_ff  <= acc_arr[c_ff];
         row_ff  <= r_ff;
         col_ff  <= c_ff;
         last_ff <= r_last && c_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, mm_pkg::IDX_W'(col_ff), mm_pkg::IDX_W'(row_ff), val_ff};
   assign rsp_tlast  = last_ff;

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (ld_row_ff == '0 && ld_col_ff == '0 && !ld_b_ff))
      else $error("load not restarted after register write");

   a_b_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(b_we_vec))
      else $error("B item written to more than one cell");

   a_emit_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_EMIT) |-> (DW'(c_ff) < cb && DW'(r_ff) < ra))
      else $error("output index beyond dimensions");

endmodule

[verif/mm_checker.sv]
// Checker for the matrix multiply unit: predicts C from the observed items and compares.
`timescale 1ns / 1ps
module mm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [15:0]                   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [mm_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mm_pkg::DIM_W-1:0]      csr_data,
   output int                            n_pending,
   output int                            n_fail
);
   import mm_pkg::*;

   typedef struct packed {
      logic [ACC_W-1:0] value;
      logic [2:0]       row;
      logic [2:0]       col;
      logic             last;
   } c_elem_t;

   c_elem_t           c_queue[$];
   logic signed [15:0] a_mat[64];
   logic signed [15:0] b_mat[64];
   logic [DIM_W-1:0]  dim_rows, dim_inner, dim_cols;
   int                load_cnt;

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(v);
   endfunction

   task automatic take_elem(logic signed [15:0] v);
      int ra, id, cb, a_len, total;
      longint acc;
      c_elem_t e;
      ra = clamp_dim(dim_rows);
      id = clamp_dim(dim_inner);
      cb = clamp_dim(dim_cols);
      a_len = ra * id;
      total = a_len + id * cb;
      if (load_cnt >= total) load_cnt = 0;
      if (load_cnt < a_len) a_mat[load_cnt] = v;
      else b_mat[load_cnt - a_len] = v;
      load_cnt++;
      if (load_cnt < total) return;
      load_cnt = 0;
      for (int r = 0; r < ra; r++) begin
         for (int c = 0; c < cb; c++) begin
            acc = 0;
            for (int k = 0; k < id; k++)
               acc += longint'(a_mat[r*id+k]) * longint'(b_mat[k*cb+c]);
            e.value = acc[ACC_W-1:0];
            e.row   = r[2:0];
            e.col   = c[2:0];
            e.last  = (r == ra-1) && (c == cb-1);
            c_queue.push_back(e);
         end
      end
   endtask

   assign n_pending = c_queue.size();

   always @(posedge clock) begin
      c_elem_t want, got;
      if (reset) begin
         dim_rows  = 4'd8;
         dim_inner = 4'd8;
         dim_cols  = 4'd8;
         load_cnt  = 0;
         c_queue.delete();
         n_fail    <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_A:    begin dim_rows  = csr_data; load_cnt = 0; end
               CSR_INNER_DIM: begin dim_inner = csr_data; load_cnt = 0; end
               CSR_COLS_B:    begin dim_cols  = csr_data; load_cnt = 0; end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_elem(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[ACC_W-1:0];
            got.row   = rsp_tdata[ACC_W+2:ACC_W];
            got.col   = rsp_tdata[ACC_W+5:ACC_W+3];
            got.last  = rsp_tlast;
            if (c_queue.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, got);
               n_fail <= n_fail + 1;
            end else begin
               want = c_queue.pop_front();
               if (want !== got) begin
                  $display({"%0t: mismatch value/row/col/last expected %h %0d %0d %b,",
                            " actual %h %0d %0d %b"},
                           $time, want.value, want.row, want.col, want.last,
                           got.value, got.row, got.col, got.last);
                  n_fail <= n_fail + 1;
               end
            end
         end
      end
   end
endmodule

[verif/tb_top.sv]
// Top-level testbench of the matrix multiply unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;
   import mm_pkg::*;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROWS_A;
   logic [DIM_W-1:0]     csr_data = '0;
   int                   n_pending, n_fail;
   int                   burst_left = 0;
   int                   elems_sent = 0;
   bit                   want_hold = 0;

   always #5 clock = ~clock;

   matrix_multiply_unit u_top (.*);

   mm_checker u_chk (.*);

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // receiver: stall pattern is picked at random, again and again; long hold on request
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 2);
         repeat (64) begin
            @(posedge clock);
            if (want_hold) begin
               rsp_tready <= 0;
               repeat (400) @(posedge clock);
               want_hold = 0;
            end
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_elem(logic [15:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      elems_sent++;
   endtask

   task automatic go_idle();
      req_tvalid <= 0;
      burst_left = 0;
      @(posedge clock);
      wait (n_pending == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic set_dims(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] id, logic [DIM_W-1:0] cb);
      write_reg(CSR_ROWS_A, ra);
      write_reg(CSR_INNER_DIM, id);
      write_reg(CSR_COLS_B, cb);
   endtask

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 11))
         0: return 4'd8;
         1: return 4'd0;
         2: return 4'($urandom_range(9, 15));
         3: return 4'($urandom_range(5, 7));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic int eff(logic [DIM_W-1:0] v);
      return (v == 0) ? 1 : (v > 8) ? 8 : int'(v);
   endfunction

   initial begin
      logic [DIM_W-1:0] ra, id, cb;
      int total, loads, part;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: 1x1x1 extremes
      set_dims(4'd1, 4'd1, 4'd1);
      send_elem(16'h7fff); send_elem(16'h7fff);
      send_elem(16'h8000); send_elem(16'h8000);
      send_elem(16'h7fff); send_elem(16'h8000);
      send_elem(16'h0000); send_elem(16'hffff);
      go_idle();
      // directed: zero and oversized dimensions clamp
      set_dims(4'd0, 4'd1, 4'd15);
      for (int i = 0; i < 9; i++) send_elem(i[0] ? 16'h8000 : 16'h7fff);
      go_idle();
      // directed: register write mid-load restarts it; unused index leaves it
      set_dims(4'd2, 4'd1, 4'd2);
      send_elem(16'h1234); send_elem(16'h4321);
      go_idle();
      write_reg(2'd3, 4'd5);
      write_reg(CSR_ROWS_A, 4'd2);
      for (int i = 0; i < 4; i++) send_elem(rand_elem());
      go_idle();

      // full size, every item 16'h8000, while the receiver holds off; keep offering items
      set_dims(4'd8, 4'd8, 4'd8);
      want_hold = 1;
      for (int i = 0; i < 192; i++) send_elem(16'h8000);
      go_idle();

      while (elems_sent < 420) begin
         ra = rand_dim(); id = rand_dim(); cb = rand_dim();
         set_dims(ra, id, cb);
         total = eff(ra) * eff(id) + eff(id) * eff(cb);
         loads = $urandom_range(1, 3);
         if (elems_sent + loads * total > 440) loads = 1;
         for (int l = 0; l < loads; l++)
            for (int i = 0; i < total; i++) send_elem(rand_elem());
         if ($urandom_range(0, 4) == 0 && total > 1) begin
            part = $urandom_range(1, total - 1);
            for (int i = 0; i < part; i++) send_elem(rand_elem());
         end
         go_idle();
      end

      wait (n_pending == 0);
      repeat (60) @(posedge clock);
      if (n_fail == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
